FILE: design/ksct_pkg.sv
// ksct_pkg: shared widths, hash constants and defaults for the k-mer strand count table
// no dependencies; imported by ksct_hash, kmer_strand_count_table_top, ksct_checker and the testbench
package ksct_pkg;

  localparam int KEY_W     = 64;
  localparam int HALF_W    = KEY_W / 2;
  localparam int CNT_W     = 8;
  localparam int KLEN_W    = 6;
  localparam int MAX_BASES = KEY_W / 2;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_PROBES_DEF    = 16;

  localparam logic [KLEN_W-1:0] KMER_LEN_RST = KLEN_W'(21);
  localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;

  // multiplicative hash and xor-shift mix
  localparam logic [KEY_W-1:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam int               HASH_SHIFT = 29;

  // base complement: A<->T, C<->G
  localparam logic [1:0] COMP_BITS = 2'b10;

endpackage

FILE: design/kmer_strand_count_table_top.sv
// kmer_strand_count_table_top: strand-aware k-mer count table, open addressing, linear probing
// depends on ksct_pkg and ksct_hash
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  input    | start, busy           | in_func, in_kmer
//  result   | out_valid (strobe)    | out_unique_res, out_forward_count,
//           |                       | out_reverse_count, out_table_full
//  config   | cfg_valid, cfg_ready  | cfg_kmer_length
//
// a count transaction hashes both strands (with extra fold and quotient steps when
// TABLE_ENTRIES is not a power of two), then does claim fwd, claim rev, find fwd, find rev,
// each probe being a read state and a compare state on the table memory; a query only
// does the finds
// after reset the table is swept clear, one entry at a time, with busy high; cfg is taken any time
// the result strobe lasts one cycle and cannot be held off; busy stays high until it shows
module kmer_strand_count_table_top
  import ksct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_PROBES    = MAX_PROBES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_kmer,
  output logic              out_valid,
  output logic              out_unique_res,
  output logic [CNT_W-1:0]  out_forward_count,
  output logic [CNT_W-1:0]  out_reverse_count,
  output logic              out_table_full,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KLEN_W-1:0] cfg_kmer_length
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int PRB_W  = $clog2(MAX_PROBES + 1);
  localparam logic [SLOT_W:0] N_L = (SLOT_W + 1)'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH_F, S_HASH_R, S_PRD, S_PCMP
  } state_t;

  typedef enum logic [1:0] {
    OP_CLAIM_F, OP_CLAIM_R, OP_FIND_F, OP_FIND_R
  } op_t;

  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] cnt;
    logic [KEY_W-1:0] key;
  } entry_t;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [KLEN_W-1:0]  klen_r;
  logic [SLOT_W-1:0]  clr_addr_r;
  logic               func_r;
  logic [KEY_W-1:0]   fwd_r, rev_r;
  logic [SLOT_W-1:0]  home_f_r, home_r_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [PRB_W-1:0]   prb_cnt_r;
  logic               full_r;
  logic [CNT_W-1:0]   fc_r;
  logic               hs_r;
  logic               out_valid_r;
  logic               out_unique_r;
  logic [CNT_W-1:0]   out_fc_r, out_rc_r;
  logic               out_full_r;

  entry_t             tbl_mem [TABLE_ENTRIES];
  entry_t             rd_word_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  entry_t             mem_wd;

  logic [KLEN_W-1:0]  k_eff;
  logic [KEY_W-1:0]   used_mask, fwd_c, rc_full, rev_c;
  logic [6:0]         rc_sh;
  logic               hash_done;
  logic [SLOT_W-1:0]  hash_slot;
  logic [KEY_W-1:0]   hash_key;
  logic               is_claim, is_fwd, hit, empty, last_prb, op_end;
  logic [KEY_W-1:0]   key_cur;
  logic [CNT_W-1:0]   cnt_inc, find_cnt;
  logic [SLOT_W:0]    slot_inc;
  logic [SLOT_W-1:0]  slot_adv;
  logic               accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // length register: zero acts as one, anything past 32 as 32
  always_comb begin
    if (klen_r == '0) k_eff = KLEN_W'(1);
    else if (klen_r > KLEN_W'(MAX_BASES)) k_eff = KLEN_W'(MAX_BASES);
    else k_eff = klen_r;
  end

  assign used_mask = (k_eff == KLEN_W'(MAX_BASES)) ? '1
                   : (KEY_W'(1) << {k_eff, 1'b0}) - KEY_W'(1);
  assign fwd_c = in_kmer & used_mask;

  // complement and reverse all 32 bases, then drop the unused ones off the bottom
  always_comb begin
    for (int i = 0; i < MAX_BASES; i++) begin
      rc_full[2*(MAX_BASES-1-i) +: 2] = fwd_c[2*i +: 2] ^ COMP_BITS;
    end
  end
  assign rc_sh = {KLEN_W'(MAX_BASES) - k_eff, 1'b0};
  assign rev_c = rc_full >> rc_sh;

  assign hash_key = (state_r == S_HASH_R) ? rev_r : fwd_r;

  ksct_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOT_W        (SLOT_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hs_r),
    .key   (hash_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  // probe compare
  assign is_claim = (op_r == OP_CLAIM_F) || (op_r == OP_CLAIM_R);
  assign is_fwd   = (op_r == OP_CLAIM_F) || (op_r == OP_FIND_F);
  assign key_cur  = is_fwd ? fwd_r : rev_r;
  assign empty    = !rd_word_r.vld;
  assign hit      = rd_word_r.vld && (rd_word_r.key == key_cur);
  assign last_prb = (prb_cnt_r == PRB_W'(MAX_PROBES - 1));
  assign op_end   = empty || hit || last_prb;
  assign cnt_inc  = (rd_word_r.cnt == COUNT_MAX) ? COUNT_MAX : rd_word_r.cnt + 1'b1;
  assign find_cnt = hit ? rd_word_r.cnt : '0;
  assign slot_inc = {1'b0, slot_r} + 1'b1;
  assign slot_adv = (slot_inc == N_L) ? '0 : slot_inc[SLOT_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_r;
    mem_wd = '{vld: 1'b1, cnt: cnt_inc, key: key_cur};
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else if (state_r == S_PCMP && is_claim && (empty || hit)) begin
      mem_we = 1'b1;
      if (empty) mem_wd.cnt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[mem_wa] <= mem_wd;
    rd_word_r <= tbl_mem[slot_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_addr_r == SLOT_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (start) state_nxt = S_HASH_F;
      S_HASH_F: if (hash_done) state_nxt = S_HASH_R;
      S_HASH_R: if (hash_done) state_nxt = S_PRD;
      S_PRD:    state_nxt = S_PCMP;
      S_PCMP:   state_nxt = (op_end && op_r == OP_FIND_R) ? S_IDLE : S_PRD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      klen_r      <= KMER_LEN_RST;
      hs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hs_r        <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) klen_r <= cfg_kmer_length;
      case (state_r)
        S_CLEAR: clr_addr_r <= clr_addr_r + 1'b1;
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func;
            fwd_r  <= fwd_c;
            rev_r  <= rev_c;
            full_r <= 1'b0;
            hs_r   <= 1'b1;
          end
        end
        S_HASH_F: begin
          if (hash_done) begin
            home_f_r <= hash_slot;
            hs_r     <= 1'b1;
          end
        end
        S_HASH_R: begin
          if (hash_done) begin
            home_r_r  <= hash_slot;
            op_r      <= func_r ? OP_FIND_F : OP_CLAIM_F;
            slot_r    <= home_f_r;
            prb_cnt_r <= '0;
          end
        end
        S_PCMP: begin
          if (op_end) begin
            prb_cnt_r <= '0;
            if (is_claim && !empty && !hit) full_r <= 1'b1;
            case (op_r)
              OP_CLAIM_F: begin
                op_r   <= OP_CLAIM_R;
                slot_r <= home_r_r;
              end
              OP_CLAIM_R: begin
                op_r   <= OP_FIND_F;
                slot_r <= home_f_r;
              end
              OP_FIND_F: begin
                fc_r   <= find_cnt;
                op_r   <= OP_FIND_R;
                slot_r <= home_r_r;
              end
              OP_FIND_R: begin
                out_valid_r  <= 1'b1;
                out_fc_r     <= fc_r;
                out_rc_r     <= find_cnt;
                out_unique_r <= (fc_r == CNT_W'(1)) && (find_cnt == CNT_W'(1));
                out_full_r   <= full_r;
              end
              default: ;
            endcase
          end else begin
            slot_r    <= slot_adv;
            prb_cnt_r <= prb_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_unique_res    = out_unique_r;
  assign out_forward_count = out_fc_r;
  assign out_reverse_count = out_rc_r;
  assign out_table_full    = out_full_r;

endmodule

FILE: design/ksct_hash.sv
// ksct_hash: home slot of a 64-bit key, multiply by the hash constant, xor-shift, reduce
// one shared 32x32 multiplier: four steps for the product, then word folds and a
// reciprocal quotient estimate for table sizes that are not a power of two; depends on ksct_pkg
module ksct_hash
  import ksct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SLOT_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // 2^32 mod N folds the upper word down, floor(2^32 / N) estimates the quotient
  localparam logic [KEY_W-1:0]  WORD_SPAN = KEY_W'(1) << HALF_W;
  localparam logic [HALF_W-1:0] FOLD_R    = HALF_W'(WORD_SPAN % KEY_W'(TABLE_ENTRIES));
  localparam logic [HALF_W-1:0] RECIP_M   = HALF_W'(WORD_SPAN / KEY_W'(TABLE_ENTRIES));
  localparam logic [HALF_W-1:0] N_W       = HALF_W'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    H_IDLE, H_MUL0, H_MUL1, H_MUL2, H_MUL3, H_MIX,
    H_FOLD, H_FADD, H_QMUL, H_QN, H_QSUB
  } hstate_t;

  hstate_t             state_r, state_nxt;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    prod_r;
  logic [KEY_W-1:0]    acc_r;
  logic [KEY_W-1:0]    hv_r;
  logic                done_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [KEY_W-1:0]    mixed;
  logic                hv_hi_nz;
  logic [HALF_W-1:0]   diff, rem_fix;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = key_r[HALF_W-1:0];
    mul_b = HASH_MULT[HALF_W-1:0];
    case (state_r)
      H_MUL1:  mul_a = key_r[KEY_W-1:HALF_W];
      H_MUL2:  mul_b = HASH_MULT[KEY_W-1:HALF_W];
      H_FOLD: begin
        mul_a = hv_r[KEY_W-1:HALF_W];
        mul_b = FOLD_R;
      end
      H_QMUL: begin
        mul_a = hv_r[HALF_W-1:0];
        mul_b = RECIP_M;
      end
      H_QN: begin
        mul_a = prod_r[KEY_W-1:HALF_W];
        mul_b = N_W;
      end
      default: ;
    endcase
  end

  assign mixed    = acc_r ^ (acc_r >> HASH_SHIFT);
  assign hv_hi_nz = |hv_r[KEY_W-1:HALF_W];
  // quotient estimate is at most one short, so one correction is enough
  assign diff     = hv_r[HALF_W-1:0] - prod_r[HALF_W-1:0];
  assign rem_fix  = (diff >= N_W) ? diff - N_W : diff;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      H_IDLE:  if (start) state_nxt = H_MUL0;
      H_MUL0:  state_nxt = H_MUL1;
      H_MUL1:  state_nxt = H_MUL2;
      H_MUL2:  state_nxt = H_MUL3;
      H_MUL3:  state_nxt = H_MIX;
      H_MIX:   state_nxt = IS_POW2 ? H_IDLE : H_FOLD;
      H_FOLD:  state_nxt = hv_hi_nz ? H_FADD : H_QMUL;
      H_FADD:  state_nxt = H_FOLD;
      H_QMUL:  state_nxt = H_QN;
      H_QN:    state_nxt = H_QSUB;
      H_QSUB:  state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      prod_r  <= mul_a * mul_b;
      case (state_r)
        H_IDLE: if (start) key_r <= key;
        H_MUL1: acc_r <= prod_r;
        H_MUL2: acc_r[KEY_W-1:HALF_W] <= acc_r[KEY_W-1:HALF_W] + prod_r[HALF_W-1:0];
        H_MUL3: acc_r[KEY_W-1:HALF_W] <= acc_r[KEY_W-1:HALF_W] + prod_r[HALF_W-1:0];
        H_MIX: begin
          hv_r <= mixed;
          if (IS_POW2) begin
            slot_r <= mixed[SLOT_W-1:0];
            done_r <= 1'b1;
          end
        end
        // hi * (2^32 mod N) + lo keeps the residue; folding repeats while the upper word is nonzero
        H_FADD: hv_r <= prod_r + {{HALF_W{1'b0}}, hv_r[HALF_W-1:0]};
        H_QSUB: begin
          slot_r <= rem_fix[SLOT_W-1:0];
          done_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

FILE: design/ksct_checker.sv
// ksct_checker: port-level checks on the k-mer strand count table, bound to the top level
// depends on ksct_pkg and kmer_strand_count_table_top
module ksct_checker
  import ksct_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_unique_res,
  input logic [CNT_W-1:0] out_forward_count,
  input logic [CNT_W-1:0] out_reverse_count
);

  // a result only closes a transaction that was in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without a transaction in progress");

  // accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_valid)
    else $error("block not busy after accepting a transaction");

  // strobe lasts one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // unique only when both strands count exactly one
  a_unique_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unique_res) |->
      (out_forward_count == CNT_W'(1)) && (out_reverse_count == CNT_W'(1)))
    else $error("unique flag with counts other than one");

endmodule

bind kmer_strand_count_table_top ksct_checker u_ksct_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_unique_res    (out_unique_res),
  .out_forward_count (out_forward_count),
  .out_reverse_count (out_reverse_count)
);

FILE: sim/ksct_tb_pkg.sv
`timescale 1ns / 100ps
// ksct_tb_pkg: transaction codes shared by the k-mer count table checker and stimulus
// no dependencies
package ksct_tb_pkg;

  typedef enum logic {
    FUNC_COUNT = 1'b0,
    FUNC_QUERY = 1'b1
  } kmer_func_e;

endpackage

FILE: sim/ksct_checker.sv
`timescale 1ns / 100ps
// ksct_scoreboard: watches the input, config and result channels of the k-mer count table,
// keeps its own copy of the hash table and compares every result field by field
// depends on ksct_pkg and ksct_tb_pkg
module ksct_scoreboard
  import ksct_pkg::*;
  import ksct_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_kmer,
  input  logic              out_valid,
  input  logic              out_unique_res,
  input  logic [CNT_W-1:0]  out_forward_count,
  input  logic [CNT_W-1:0]  out_reverse_count,
  input  logic              out_table_full,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [KLEN_W-1:0] cfg_kmer_length,
  output int                results_pending,
  output int                mismatch_count
);

  typedef struct {
    logic [KEY_W-1:0] kmer;
    logic             unique_res;
    logic [CNT_W-1:0] forward_count;
    logic [CNT_W-1:0] reverse_count;
    logic             table_full;
  } strand_counts_t;

  logic [KEY_W-1:0]  key_mem   [TABLE_ENTRIES_DEF];
  logic [CNT_W-1:0]  count_mem [TABLE_ENTRIES_DEF];
  bit                slot_used [TABLE_ENTRIES_DEF];
  logic [KLEN_W-1:0] kmer_len_reg;
  strand_counts_t    awaited_counts[$];
  strand_counts_t    oldest;

  function automatic int bases_in_use(logic [KLEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_BASES) return MAX_BASES;
    return int'(len);
  endfunction

  function automatic logic [KEY_W-1:0] reverse_complement(logic [KEY_W-1:0] fwd, int bases);
    logic [KEY_W-1:0] rc;
    int i;
    rc = '0;
    for (i = 0; i < bases; i++) begin
      rc[2*(bases-1-i) +: 2] = fwd[2*i +: 2] ^ COMP_BITS;
    end
    return rc;
  endfunction

  function automatic int home_slot(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] h;
    h = key * HASH_MULT;
    h ^= h >> HASH_SHIFT;
    return int'(h % TABLE_ENTRIES_DEF);
  endfunction

  function automatic int lookup_slot(logic [KEY_W-1:0] key);
    int s;
    int p;
    s = home_slot(key);
    for (p = 0; p < MAX_PROBES_DEF; p++) begin
      if (!slot_used[s]) return -1;
      if (key_mem[s] == key) return s;
      s = (s + 1) % TABLE_ENTRIES_DEF;
    end
    return -1;
  endfunction

  // finds or claims the entry and bumps it, returns 1 when the probe window is full
  function automatic bit count_strand(logic [KEY_W-1:0] key);
    int s;
    int p;
    s = home_slot(key);
    for (p = 0; p < MAX_PROBES_DEF; p++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        key_mem[s]   = key;
        count_mem[s] = CNT_W'(1);
        return 1'b0;
      end
      if (key_mem[s] == key) begin
        if (count_mem[s] != COUNT_MAX) count_mem[s]++;
        return 1'b0;
      end
      s = (s + 1) % TABLE_ENTRIES_DEF;
    end
    return 1'b1;
  endfunction

  function automatic strand_counts_t predict_counts(logic func, logic [KEY_W-1:0] kmer);
    strand_counts_t   r;
    int               bases;
    int               sf;
    int               sr;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] fwd;
    logic [KEY_W-1:0] rev;
    bases = bases_in_use(kmer_len_reg);
    mask  = (bases == MAX_BASES) ? '1 : (KEY_W'(1) << (2 * bases)) - KEY_W'(1);
    fwd   = kmer & mask;
    rev   = reverse_complement(fwd, bases);
    r.kmer       = kmer;
    r.table_full = 1'b0;
    // a palindrome hits the same entry twice
    if (func == FUNC_COUNT) begin
      if (count_strand(fwd)) r.table_full = 1'b1;
      if (count_strand(rev)) r.table_full = 1'b1;
    end
    sf = lookup_slot(fwd);
    sr = lookup_slot(rev);
    r.forward_count = (sf < 0) ? '0 : count_mem[sf];
    r.reverse_count = (sr < 0) ? '0 : count_mem[sr];
    r.unique_res    = (r.forward_count == CNT_W'(1)) && (r.reverse_count == CNT_W'(1));
    return r;
  endfunction

  task automatic note_mismatch(string what);
    if (mismatch_count < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      kmer_len_reg = KMER_LEN_RST;
      awaited_counts.delete();
    end else begin
      if (out_valid) begin
        if (awaited_counts.size() == 0) begin
          note_mismatch($sformatf("unexpected result: u=%0b f=%0d r=%0d full=%0b",
                                  out_unique_res, out_forward_count, out_reverse_count,
                                  out_table_full));
        end else begin
          oldest = awaited_counts.pop_front();
          if (out_unique_res !== oldest.unique_res ||
              out_forward_count !== oldest.forward_count ||
              out_reverse_count !== oldest.reverse_count ||
              out_table_full !== oldest.table_full) begin
            note_mismatch({$sformatf("kmer %h: exp u=%0b f=%0d r=%0d full=%0b",
                                     oldest.kmer, oldest.unique_res, oldest.forward_count,
                                     oldest.reverse_count, oldest.table_full),
                           $sformatf(", got u=%0b f=%0d r=%0d full=%0b",
                                     out_unique_res, out_forward_count,
                                     out_reverse_count, out_table_full)});
          end
        end
      end
      if (cfg_valid && cfg_ready) kmer_len_reg = cfg_kmer_length;
      if (start && !busy) begin
        awaited_counts = {awaited_counts, predict_counts(in_func, in_kmer)};
      end
    end
    results_pending = awaited_counts.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives directed and random k-mer transactions and length settings into the count table
// depends on ksct_pkg, ksct_tb_pkg, ksct_scoreboard and kmer_strand_count_table_top
module tb_top;
  import ksct_pkg::*;
  import ksct_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int POOL_SIZE    = 24;
  localparam int SLOT_BITS    = $clog2(TABLE_ENTRIES_DEF);
  localparam int WRAP_SLOT    = TABLE_ENTRIES_DEF - 6;
  localparam int RECENT_DEPTH = 8;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_func;
  logic [KEY_W-1:0]  in_kmer;
  logic              out_valid;
  logic              out_unique_res;
  logic [CNT_W-1:0]  out_forward_count;
  logic [CNT_W-1:0]  out_reverse_count;
  logic              out_table_full;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [KLEN_W-1:0] cfg_kmer_length;

  int results_pending;
  int mismatch_count;
  int cycle_count;

  // keys that all hash to the same slot near the top of the table, to fill a probe window
  logic [KEY_W-1:0] colliding_kmers[POOL_SIZE];
  logic [KEY_W-1:0] recent_kmers[$];

  kmer_strand_count_table_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_kmer           (in_kmer),
    .out_valid         (out_valid),
    .out_unique_res    (out_unique_res),
    .out_forward_count (out_forward_count),
    .out_reverse_count (out_reverse_count),
    .out_table_full    (out_table_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_kmer_length   (cfg_kmer_length)
  );

  ksct_scoreboard u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_kmer           (in_kmer),
    .out_valid         (out_valid),
    .out_unique_res    (out_unique_res),
    .out_forward_count (out_forward_count),
    .out_reverse_count (out_reverse_count),
    .out_table_full    (out_table_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_kmer_length   (cfg_kmer_length),
    .results_pending   (results_pending),
    .mismatch_count    (mismatch_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // busy is sampled at the falling edge, where it holds the value the next rising edge sees
  task automatic send_kmer(kmer_func_e f, logic [KEY_W-1:0] k, int idle_pct);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_func <= f;
    in_kmer <= k;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic set_kmer_length(logic [KLEN_W-1:0] len);
    bit taken;
    cfg_valid       <= 1'b1;
    cfg_kmer_length <= len;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(logic [KLEN_W-1:0] len, int items, int idle_pct, bit use_pool,
                           int hammer_pct);
    logic [KEY_W-1:0] kmer;
    kmer_func_e       f;
    int               pick;
    int               n;
    wait_for_results();
    set_kmer_length(len);
    for (n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      kmer = {$urandom, $urandom};
      f    = ($urandom_range(0, 99) < 60) ? FUNC_COUNT : FUNC_QUERY;
      if (pick < hammer_pct) begin
        // AT is its own reverse complement at two bases, counted twice until it saturates
        kmer[3:0] = 4'b0010;
        f = FUNC_COUNT;
      end else if (use_pool && pick < hammer_pct + 35) begin
        kmer = colliding_kmers[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < hammer_pct + 70 && recent_kmers.size() != 0) begin
        kmer = recent_kmers[$urandom_range(0, recent_kmers.size() - 1)];
      end
      recent_kmers = {recent_kmers, kmer};
      if (recent_kmers.size() > RECENT_DEPTH) void'(recent_kmers.pop_front());
      send_kmer(f, kmer, idle_pct);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] mult_inv;
    logic [KEY_W-1:0] h;
    int               i;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = FUNC_COUNT;
    in_kmer         = '0;
    cfg_valid       = 1'b0;
    cfg_kmer_length = '0;

    // invert the odd hash multiplier mod 2^64, then pick mixed values landing on WRAP_SLOT
    mult_inv = HASH_MULT;
    repeat (6) mult_inv = mult_inv * (KEY_W'(2) - HASH_MULT * mult_inv);
    for (i = 0; i < POOL_SIZE; i++) begin
      h = {$urandom, $urandom};
      h[SLOT_BITS-1:0] = SLOT_BITS'(WRAP_SLOT) ^ h[HASH_SHIFT +: SLOT_BITS];
      colliding_kmers[i] = h * mult_inv;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset length of 21 bases
    send_kmer(FUNC_COUNT, '1, 0);
    send_kmer(FUNC_QUERY, '1, 0);
    send_kmer(FUNC_QUERY, 64'h5555_5555_5555_5555, 0);
    send_kmer(FUNC_COUNT, 64'hFFFF_FC00_0000_0000, 0);
    send_kmer(FUNC_QUERY, 64'h0, 0);
    send_kmer(FUNC_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_kmer(FUNC_QUERY, 64'h0, 0);
    send_kmer(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 0);

    run_phase(KLEN_W'(1), 80, 25, 1'b0, 0);
    run_phase(KLEN_W'(2), 150, 25, 1'b0, 85);
    run_phase(KLEN_W'(32), 130, 0, 1'b1, 0);
    run_phase(KLEN_W'(0), 30, 25, 1'b0, 0);
    run_phase(KLEN_W'(63), 70, 25, 1'b1, 0);
    run_phase(KLEN_W'(11), 50, 25, 1'b0, 0);
    run_phase(KLEN_W'(3), 30, 25, 1'b0, 0);

    wait_for_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
